FILE: hdl/static_linked_list_engine_top_macros.svh
// Assertion macros for the static linked list engine checker.
// No dependencies; included by the checker file only.
`ifndef STATIC_LINKED_LIST_ENGINE_TOP_MACROS_SVH
`define STATIC_LINKED_LIST_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define SLL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define SLL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/sll_pkg.sv
// Shared constants, types and helpers for the static linked list engine.
// No dependencies.
package sll_pkg;

    localparam int NODES = 64;
    localparam int IW    = 6;
    localparam int DW    = 32;

    typedef logic [IW-1:0] t_idx;
    typedef logic [DW-1:0] t_word;

    // function codes
    localparam logic [1:0] FN_RESTART  = 2'd0;
    localparam logic [1:0] FN_INSERT   = 2'd1;
    localparam logic [1:0] FN_TRAVERSE = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BAD_POS  = 2'd2;

    // link held by an entry that has not been written since the chain was rebuilt
    function automatic t_idx dflt_link(input t_idx a);
        t_idx r;
        if (a == t_idx'(NODES - 1)) begin
            r = '0;
        end else begin
            r = a + t_idx'(1);
        end
        return r;
    endfunction

endpackage

FILE: hdl/static_linked_list_engine_top.sv
// Static linked list engine: cursor-array list held in data and link memories.
// Depends on sll_pkg.
//
// Channels: items in on i_valid / o_ready (i_func, i_value, i_position); results
//   out on o_valid / i_ready (o_status, o_node_value, o_node_index, o_next_index,
//   o_last). One item is worked on at a time; o_ready is high only while the
//   sequencer is idle, and an idle block takes a new item while a result waits.
// Work per function: restart writes entry 1, then loads its result. A successful insert does one
//   link memory read per node passed, checks the free head, reads the free and
//   position links, writes both links and loads its result; failed inserts return
//   sooner. Traverse gives one node per cycle while the output register is free,
//   up to 63 nodes; an empty list gives no result. Func 3 is dropped at the edge
//   that takes it.
// Next item: taken in the cycle after the last result is loaded, not before.
// Reset: synchronous, active low. The list is empty and the free chain runs
//   1, 2, ... 63. A valid bit per entry makes an unwritten entry read as data 0
//   and its free-chain link, so no clearing pass; restart clears them at once.
// Stalls: a result sits in the output register until taken; the sequencer holds
//   its next result until the register drains, with o_ready low meanwhile.
module static_linked_list_engine_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_func,
    input  logic signed [31:0]    i_value,
    input  logic [5:0]            i_position,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [1:0]            o_status,
    output logic signed [31:0]    o_node_value,
    output logic [5:0]            o_node_index,
    output logic [5:0]            o_next_index,
    output logic                  o_last
);
    import sll_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_RESP     = 3'd1;  // single result pending
    localparam logic [2:0] S_WALK     = 3'd2;  // following links to the position
    localparam logic [2:0] S_CHK      = 3'd3;  // free chain check
    localparam logic [2:0] S_FREE     = 3'd4;  // link of new node arrives
    localparam logic [2:0] S_LINK     = 3'd5;  // link of position node arrives
    localparam logic [2:0] S_WB       = 3'd6;  // relink position node
    localparam logic [2:0] S_TRAV     = 3'd7;  // traversal, node data arriving

    // memories (no reset; validity tracked in r_vld)
    t_word            r_data_mem [NODES];
    t_idx             r_link_mem [NODES];
    logic [NODES-1:0] r_vld, n_vld;

    // read port
    t_word r_data_q;
    t_idx  r_link_q;
    logic  r_q_vld;
    t_idx  r_q_addr;
    logic  rd_en;
    t_idx  rd_addr;
    t_idx  rd_link;
    t_word rd_data;

    // write port
    logic  wr_link_en, wr_data_en, clr_vld;
    t_idx  wr_addr, wr_link;
    t_word wr_data;

    // control state
    logic [2:0] r_state, n_state;
    t_idx       r_head, n_head;
    t_idx       r_free, n_free;
    t_idx       r_cur, n_cur;
    t_idx       r_nfree, n_nfree;     // free head after the take
    t_idx       r_cnt, n_cnt;         // walk steps left / nodes reported
    t_word      r_val, n_val;
    logic [1:0] r_res_status, n_res_status;
    t_idx       r_res_index, n_res_index;
    t_idx       r_res_next, n_res_next;

    // output register
    logic       r_o_valid;
    logic [1:0] r_o_status;
    t_word      r_o_value;
    t_idx       r_o_index, r_o_next;
    logic       r_o_last;

    logic       out_free;
    logic       o_load;
    logic [1:0] ld_status;
    t_word      ld_value;
    t_idx       ld_index, ld_next;
    logic       ld_last;
    logic       in_acc;
    logic       trav_fin;

    assign o_ready  = (r_state == S_IDLE);
    assign in_acc   = i_valid && o_ready;
    assign out_free = !r_o_valid || i_ready;

    // unwritten entries read as their reset contents
    assign rd_link  = r_q_vld ? r_link_q : dflt_link(r_q_addr);
    assign rd_data  = r_q_vld ? r_data_q : '0;
    assign trav_fin = (rd_link == '0) || (r_cnt == t_idx'(NODES - 2));

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_free       = r_free;
        n_cur        = r_cur;
        n_nfree      = r_nfree;
        n_cnt        = r_cnt;
        n_val        = r_val;
        n_res_status = r_res_status;
        n_res_index  = r_res_index;
        n_res_next   = r_res_next;
        rd_en        = 1'b0;
        rd_addr      = r_cur;
        wr_link_en   = 1'b0;
        wr_data_en   = 1'b0;
        clr_vld      = 1'b0;
        wr_addr      = r_cur;
        wr_link      = '0;
        wr_data      = r_val;
        o_load       = 1'b0;
        ld_status    = r_res_status;
        ld_value     = r_val;
        ld_index     = r_res_index;
        ld_next      = r_res_next;
        ld_last      = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_val        = i_value;
                    n_res_status = ST_BAD_POS;
                    n_res_index  = '0;
                    n_res_next   = '0;
                    case (i_func)
                        FN_RESTART: begin
                            // fresh chain; entry 1 becomes the only node
                            clr_vld      = 1'b1;
                            wr_link_en   = 1'b1;
                            wr_data_en   = 1'b1;
                            wr_addr      = t_idx'(1);
                            wr_link      = '0;
                            wr_data      = i_value;
                            n_head       = t_idx'(1);
                            n_free       = t_idx'(2);
                            n_res_status = ST_OK;
                            n_res_index  = t_idx'(1);
                            n_state      = S_RESP;
                        end
                        FN_INSERT: begin
                            n_cur = r_head;
                            if (r_head == '0) begin
                                n_state = S_RESP;
                            end else if (i_position <= t_idx'(1)) begin
                                n_state = S_CHK;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = r_head;
                                n_cnt   = i_position - t_idx'(1);
                                n_state = S_WALK;
                            end
                        end
                        FN_TRAVERSE: begin
                            if (r_head != '0) begin
                                rd_en   = 1'b1;
                                rd_addr = r_head;
                                n_cur   = r_head;
                                n_cnt   = '0;
                                n_state = S_TRAV;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RESP: begin
                if (out_free) begin
                    o_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_WALK: begin
                if (rd_link == '0) begin
                    n_state = S_RESP;          // ran off the end
                end else begin
                    n_cur = rd_link;
                    if (r_cnt == t_idx'(1)) begin
                        n_state = S_CHK;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = rd_link;
                        n_cnt   = r_cnt - t_idx'(1);
                    end
                end
            end
            S_CHK: begin
                if (r_free == '0) begin
                    n_res_status = ST_FULL;
                    n_state      = S_RESP;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_free;
                    n_state = S_FREE;
                end
            end
            S_FREE: begin
                n_nfree = rd_link;
                rd_en   = 1'b1;
                rd_addr = r_cur;
                n_state = S_LINK;
            end
            S_LINK: begin
                // new node takes over the position node's link
                wr_link_en   = 1'b1;
                wr_data_en   = 1'b1;
                wr_addr      = r_free;
                wr_link      = rd_link;
                n_res_next   = rd_link;
                n_res_index  = r_free;
                n_res_status = ST_OK;
                n_state      = S_WB;
            end
            S_WB: begin
                wr_link_en = 1'b1;
                wr_addr    = r_cur;
                wr_link    = r_free;
                n_free     = r_nfree;
                n_state    = S_RESP;
            end
            S_TRAV: begin
                if (out_free) begin
                    o_load    = 1'b1;
                    ld_status = ST_OK;
                    ld_value  = rd_data;
                    ld_index  = r_cur;
                    ld_next   = rd_link;
                    ld_last   = trav_fin;
                    if (trav_fin) begin
                        n_state = S_IDLE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = rd_link;
                        n_cur   = rd_link;
                        n_cnt   = r_cnt + t_idx'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_vld = r_vld;
        if (clr_vld) begin
            n_vld = '0;
        end
        if (wr_link_en) begin
            n_vld[wr_addr] = 1'b1;
        end
    end

    // memory port
    always_ff @(posedge i_clk) begin
        if (wr_link_en) begin
            r_link_mem[wr_addr] <= wr_link;
        end
        if (wr_data_en) begin
            r_data_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_link_q <= r_link_mem[rd_addr];
            r_data_q <= r_data_mem[rd_addr];
            r_q_vld  <= r_vld[rd_addr];
            r_q_addr <= rd_addr;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_free    <= t_idx'(1);
            r_vld     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_free  <= n_free;
            r_vld   <= n_vld;
            if (o_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cur        <= n_cur;
        r_nfree      <= n_nfree;
        r_cnt        <= n_cnt;
        r_val        <= n_val;
        r_res_status <= n_res_status;
        r_res_index  <= n_res_index;
        r_res_next   <= n_res_next;
        if (o_load) begin
            r_o_status <= ld_status;
            r_o_value  <= ld_value;
            r_o_index  <= ld_index;
            r_o_next   <= ld_next;
            r_o_last   <= ld_last;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_status     = r_o_status;
    assign o_node_value = r_o_value;
    assign o_node_index = r_o_index;
    assign o_next_index = r_o_next;
    assign o_last       = r_o_last;

endmodule

FILE: hdl/sll_checker.sv
// Port-level checker for the static linked list engine, bound to the top level.
// Depends on sll_pkg and static_linked_list_engine_top_macros.svh.
`include "static_linked_list_engine_top_macros.svh"

module sll_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_ready,
    input logic [1:0]            i_func,
    input logic signed [31:0]    i_value,
    input logic [5:0]            i_position,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic [1:0]            o_status,
    input logic signed [31:0]    o_node_value,
    input logic [5:0]            o_node_index,
    input logic [5:0]            o_next_index,
    input logic                  o_last
);
    import sll_pkg::*;

    // a stalled result holds its value, index and last flag
    `SLL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_node_value) && $stable(o_node_index) && $stable(o_last), "result changed while stalled")

    // failed requests give one result with null indexes
    `SLL_ASSERT_NOW(a_err_single, i_clk, i_rst_n, o_valid && (o_status != ST_OK), o_last && (o_node_index == '0) && (o_next_index == '0), "error result malformed")

    // a node reported before the last one must link onward
    `SLL_ASSERT_NOW(a_mid_link, i_clk, i_rst_n, o_valid && !o_last, o_next_index != '0, "non-final node ends its chain")

    // successful results never name entry zero, the null index
    `SLL_ASSERT_NOW(a_ok_index, i_clk, i_rst_n, o_valid && (o_status == ST_OK), o_node_index != '0, "result names entry zero")

endmodule

bind static_linked_list_engine_top sll_checker u_sll_checker (.*);
